// ----- rtl/core/tcld_pkg.sv -----
package tcld_pkg;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_TOOLONG = 2'd2;

    // command kinds
    localparam logic [4:0] CMD_IDLE      = 5'd0;
    localparam logic [4:0] CMD_STATUS    = 5'd1;
    localparam logic [4:0] CMD_BYPASS    = 5'd2;
    localparam logic [4:0] CMD_TRACK     = 5'd3;
    localparam logic [4:0] CMD_AUTO      = 5'd4;
    localparam logic [4:0] CMD_AMP       = 5'd5;
    localparam logic [4:0] CMD_FREQ      = 5'd6;
    localparam logic [4:0] CMD_TRIMQ     = 5'd7;
    localparam logic [4:0] CMD_PHASE     = 5'd8;
    localparam logic [4:0] CMD_PHASEQ    = 5'd9;
    localparam logic [4:0] CMD_CAL       = 5'd10;
    localparam logic [4:0] CMD_PROBE     = 5'd11;
    localparam logic [4:0] CMD_STEP      = 5'd12;
    localparam logic [4:0] CMD_SWEEP     = 5'd13;
    localparam logic [4:0] CMD_RESULT    = 5'd14;
    localparam logic [4:0] CMD_TRACKDONE = 5'd15;
    localparam logic [4:0] CMD_TASKDONE  = 5'd16;

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_DIAG   = 3'd1;
    localparam logic [2:0] MODE_CIRCLE = 3'd2;
    localparam logic [2:0] MODE_DOUBLE = 3'd3;
    localparam logic [2:0] MODE_PROBE  = 3'd4;
    localparam logic [2:0] MODE_SWEEP  = 3'd5;
    localparam logic [2:0] MODE_TABLE  = 3'd6;

    localparam logic [31:0] PROBE_DEFAULT = 32'd1000;

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_SP  = 8'd32;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NUL = 8'd0;

    // tokens are compared as up to 9 packed characters, first char in top byte
    localparam int unsigned TOK_CHARS = 9;
    typedef logic [TOK_CHARS*8-1:0] t_tok;

    // front to back queue entry: a finished line or a too-long event
    typedef struct packed {
        logic       port;
        logic       too_long;
        logic [7:0] len;
    } t_job;

    typedef struct packed {
        logic        port;
        logic [1:0]  status;
        logic [4:0]  kind;
        logic [2:0]  mode;
        logic [31:0] v1;
        logic [31:0] v2;
    } t_result;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        upcase = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
    endfunction

    function automatic t_tok tk(input string s);
        t_tok r;
        r = '0;
        for (int k = 0; k < TOK_CHARS; k++) begin
            if (k < s.len()) r[(TOK_CHARS-1-k)*8 +: 8] = s[k];
        end
        tk = r;
    endfunction

endpackage

// ----- rtl/core/text_command_line_decoder_core.sv -----
// Channel | Dir | Payload
// s_axis  | in  | tuser = port, tdata[7:0] = rx_byte
// m_axis  | out | tuser = reply_port, tdata = status, command_kind, mode, v1, v2
//
// A plain byte is stored as it is taken. A line end walks the stored line, each character
// taking a store read, then a scan, followed by handoff, decode and output; a too-long
// result skips the walk and goes from handoff straight to decode and output.
// Input stalls from a line end until the back end is idle again, and while a finished
// line waits for the back end.
// Reset (synchronous, active low) clears line counts and all handshake state.
// A stalled output holds its result; the back end then stops taking jobs.
module text_command_line_decoder_core #(
    parameter int unsigned LINE_CAPACITY = 80,
    parameter int unsigned PORT_COUNT    = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] port
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [1:0] status [6:2] kind [9:7] mode
                                        // [41:10] first_value [73:42] second_value
    output logic        m_axis_tuser    // [0] reply_port
);
    localparam int unsigned AW = $clog2(PORT_COUNT * LINE_CAPACITY);

    tcld_pkg::t_job    job;
    tcld_pkg::t_result res;
    logic job_valid, job_ready, back_busy, rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0] rd_data;

    tcld_front #(.LINE_CAPACITY(LINE_CAPACITY), .PORT_COUNT(PORT_COUNT)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_port(s_axis_tuser), .i_byte(s_axis_tdata),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job),
        .i_back_busy(back_busy),
        .i_rd_en(rd_en), .i_rd_addr(rd_addr), .o_rd_data(rd_data)
    );

    tcld_back #(.LINE_CAPACITY(LINE_CAPACITY), .PORT_COUNT(PORT_COUNT)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_busy(back_busy), .o_rd_en(rd_en), .o_rd_addr(rd_addr), .i_rd_data(rd_data),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tuser = res.port;
    assign m_axis_tdata = {6'b0, res.v2, res.v1, res.mode, res.kind, res.status};

endmodule

// ----- rtl/core/tcld_front.sv -----
module tcld_front #(
    parameter int unsigned LINE_CAPACITY = 80,
    parameter int unsigned PORT_COUNT    = 2,
    localparam int unsigned PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1,
    localparam int unsigned CW = $clog2(LINE_CAPACITY + 1),
    localparam int unsigned AW = $clog2(PORT_COUNT * LINE_CAPACITY)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_port,
    input  logic [7:0]        i_byte,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output tcld_pkg::t_job    o_job,
    input  logic              i_back_busy,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0]    r_mem [PORT_COUNT*LINE_CAPACITY];
    logic [CW-1:0] r_cnt [PORT_COUNT];
    logic          r_job_valid;
    tcld_pkg::t_job r_job;
    logic [7:0]    r_rd_data;

    logic          acc, in_range, is_eol;
    logic [PW-1:0] pidx;
    logic [CW-1:0] cur;

    assign pidx     = PW'(i_port);
    assign in_range = 32'(i_port) < PORT_COUNT;
    assign cur      = r_cnt[pidx];
    assign is_eol   = (i_byte == tcld_pkg::CH_CR) || (i_byte == tcld_pkg::CH_LF);
    // one line in flight: the store is read by the back end while it decodes
    assign o_ready  = !r_job_valid && !i_back_busy;
    assign acc      = i_valid && o_ready;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
    assign o_rd_data   = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
        if (acc && in_range && !is_eol && cur < CW'(LINE_CAPACITY - 1))
            r_mem[AW'(32'(pidx) * LINE_CAPACITY + 32'(cur))] <= i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORT_COUNT; p++) r_cnt[p] <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (r_job_valid && i_job_ready) r_job_valid <= 1'b0;
            if (acc && in_range) begin
                if (is_eol) begin
                    if (cur != '0) begin
                        r_cnt[pidx]       <= '0;
                        r_job_valid       <= 1'b1;
                        r_job.port        <= i_port;
                        r_job.too_long    <= 1'b0;
                        r_job.len         <= 8'(cur);
                    end
                end else if (cur < CW'(LINE_CAPACITY - 1)) begin
                    r_cnt[pidx] <= cur + 1'b1;
                end else begin
                    r_cnt[pidx]    <= '0;
                    r_job_valid    <= 1'b1;
                    r_job.port     <= i_port;
                    r_job.too_long <= 1'b1;
                    r_job.len      <= '0;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> !acc) else $error("byte taken while job pending");
    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && !i_job_ready |=> r_job_valid && $stable(r_job))
        else $error("job dropped");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[pidx] < CW'(LINE_CAPACITY)) else $error("count overflow");
`endif

endmodule

// ----- rtl/core/tcld_back.sv -----
module tcld_back #(
    parameter int unsigned LINE_CAPACITY = 80,
    parameter int unsigned PORT_COUNT    = 2,
    localparam int unsigned AW = $clog2(PORT_COUNT * LINE_CAPACITY)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  tcld_pkg::t_job      i_job,
    output logic                o_busy,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  logic [7:0]          i_rd_data,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output tcld_pkg::t_result   o_res
);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_DEC, S_OUT} t_state;

    t_state          r_state;
    tcld_pkg::t_job  r_job;
    logic [7:0]      r_idx;
    logic            r_pend;      // read issued last cycle
    logic [1:0]      r_tn;        // tokens started
    logic            r_in_tok;
    tcld_pkg::t_tok  r_t0, r_t1;
    logic [3:0]      r_len0, r_len1;
    // number scanners for tokens 1 and 2
    logic [1:0]      r_nph [2];   // 0 ws, 1 sign taken, 2 digits, 3 done
    logic            r_neg [2];
    logic [32:0]     r_mag [2];
    tcld_pkg::t_result r_res;
    logic            r_res_valid;

    logic [7:0] c;
    logic       sep;
    logic [1:0] ti;
    logic [35:0] m10 [2];

    assign c   = tcld_pkg::upcase(i_rd_data);
    assign sep = (c == tcld_pkg::CH_SP) || (c == tcld_pkg::CH_TAB);
    // char belongs to token tn-1 (continuing) or opens token tn
    assign ti  = r_in_tok ? r_tn - 2'd1 : r_tn;
    assign o_job_ready = (r_state == S_IDLE) && !r_res_valid;
    assign o_busy      = r_state != S_IDLE;
    assign o_rd_en     = (r_state == S_READ);
    assign o_rd_addr   = AW'(32'(r_job.port) * LINE_CAPACITY + 32'(r_idx));
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        for (int j = 0; j < 2; j++)
            m10[j] = {3'b0, r_mag[j]} * 36'd10 + 36'(c - 8'd48);
    end

    function automatic logic [31:0] num_u(input logic neg, input logic [32:0] m);
        if (m[32]) num_u = '1;
        else num_u = neg ? 32'(0) - m[31:0] : m[31:0];
    endfunction

    function automatic logic [31:0] num_s(input logic neg, input logic [32:0] m);
        if (neg) num_s = (m >= 33'h080000000) ? 32'h80000000 : 32'(0) - m[31:0];
        else     num_s = (m > 33'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    endfunction

    function automatic logic [2:0] mode_of(input tcld_pkg::t_tok t);
        if      (t == tcld_pkg::tk("DIAG"))   mode_of = tcld_pkg::MODE_DIAG;
        else if (t == tcld_pkg::tk("CIRCLE")) mode_of = tcld_pkg::MODE_CIRCLE;
        else if (t == tcld_pkg::tk("DOUBLE")) mode_of = tcld_pkg::MODE_DOUBLE;
        else if (t == tcld_pkg::tk("PROBE"))  mode_of = tcld_pkg::MODE_PROBE;
        else if (t == tcld_pkg::tk("SWEEP"))  mode_of = tcld_pkg::MODE_SWEEP;
        else if (t == tcld_pkg::tk("TABLE"))  mode_of = tcld_pkg::MODE_TABLE;
        else                                  mode_of = tcld_pkg::MODE_NONE;
    endfunction

    tcld_pkg::t_tok t0, t1;
    logic a1, a2, ok;
    logic [4:0] kind;
    logic [2:0] md;
    logic [31:0] v1, v2, u1, u2;

    // over-long tokens (>9 chars) never match: mark them as all ones
    assign t0 = (r_len0 > 4'd9) ? '1 : r_t0;
    assign t1 = (r_len1 > 4'd9) ? '1 : r_t1;
    assign u1 = num_u(r_neg[0], r_mag[0]);
    assign u2 = num_u(r_neg[1], r_mag[1]);

    always_comb begin
        a1 = r_tn > 2'd1;
        a2 = r_tn > 2'd2;
        ok = 1'b1; kind = tcld_pkg::CMD_IDLE; md = tcld_pkg::MODE_NONE;
        v1 = '0; v2 = '0;
        priority if (r_tn == 2'd0) ok = 1'b0;
        else if (t0 == tcld_pkg::tk("IDLE") || t0 == tcld_pkg::tk("OFF"))
            kind = tcld_pkg::CMD_IDLE;
        else if (t0 == tcld_pkg::tk("STATUS")) kind = tcld_pkg::CMD_STATUS;
        else if (t0 == tcld_pkg::tk("BYPASS")) kind = tcld_pkg::CMD_BYPASS;
        else if ((t0 == tcld_pkg::tk("TRACK") || t0 == tcld_pkg::tk("AUTO")) && a1) begin
            kind = (t0 == tcld_pkg::tk("TRACK")) ? tcld_pkg::CMD_TRACK : tcld_pkg::CMD_AUTO;
            md = mode_of(t1);
            ok = md != tcld_pkg::MODE_NONE;
        end
        else if (t0 == tcld_pkg::tk("AMP") && a1) begin kind = tcld_pkg::CMD_AMP; v1 = u1; end
        else if (t0 == tcld_pkg::tk("FREQ") && a1) begin kind = tcld_pkg::CMD_FREQ; v1 = u1; end
        else if (t0 == tcld_pkg::tk("TRIMQ") && a1) begin
            kind = tcld_pkg::CMD_TRIMQ; v1 = num_s(r_neg[0], r_mag[0]);
        end
        else if (t0 == tcld_pkg::tk("PHASE") && a1) begin
            kind = tcld_pkg::CMD_PHASE; v1 = u1;
        end
        else if (t0 == tcld_pkg::tk("PHASEQ") && a1) begin
            kind = tcld_pkg::CMD_PHASEQ; v1 = u1;
        end
        else if (t0 == tcld_pkg::tk("CAL") && a2) begin
            kind = tcld_pkg::CMD_CAL; v1 = u1; v2 = u2;
        end
        else if (t0 == tcld_pkg::tk("PROBE")) begin
            kind = tcld_pkg::CMD_PROBE;
            v1 = a1 ? u1 : tcld_pkg::PROBE_DEFAULT;
            v2 = a2 ? u2 : '0;
        end
        else if (t0 == tcld_pkg::tk("STEP") && a1) begin kind = tcld_pkg::CMD_STEP; v1 = u1; end
        else if (t0 == tcld_pkg::tk("SWEEP")) kind = tcld_pkg::CMD_SWEEP;
        else if (t0 == tcld_pkg::tk("RESULT")) begin
            kind = tcld_pkg::CMD_RESULT; v1 = a1 ? u1 : '0;
        end
        else if (t0 == tcld_pkg::tk("TRACKDONE") && a2) begin
            kind = tcld_pkg::CMD_TRACKDONE; v1 = u1; v2 = u2;
        end
        else if (t0 == tcld_pkg::tk("TASKDONE") && a2) begin
            kind = tcld_pkg::CMD_TASKDONE; v1 = u1; v2 = u2;
        end
        else ok = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid && !r_res_valid) begin
                        r_job <= i_job;
                        r_idx <= '0; r_tn <= '0; r_in_tok <= 1'b0;
                        r_t0 <= '0; r_t1 <= '0; r_len0 <= '0; r_len1 <= '0;
                        for (int j = 0; j < 2; j++) begin
                            r_nph[j] <= 2'd0; r_neg[j] <= 1'b0; r_mag[j] <= '0;
                        end
                        r_state <= i_job.too_long ? S_DEC : S_READ;
                    end
                end
                S_READ: begin
                    r_pend  <= 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_pend <= 1'b0;
                    if (c == tcld_pkg::CH_NUL) begin
                    end else if (sep) r_in_tok <= 1'b0;
                    else if (r_in_tok || r_tn != 2'd3) begin
                        if (!r_in_tok) begin
                            r_tn <= r_tn + 2'd1; r_in_tok <= 1'b1;
                        end
                        if (ti == 2'd0) begin
                            if (r_len0 < 4'd10) r_len0 <= r_len0 + 4'd1;
                            r_t0 <= r_t0 | (tcld_pkg::t_tok'(c) << (8*(8 - 32'(r_len0))));
                        end else begin
                            if (ti == 2'd1) begin
                                if (r_len1 < 4'd10) r_len1 <= r_len1 + 4'd1;
                                r_t1 <= r_t1 | (tcld_pkg::t_tok'(c) << (8*(8 - 32'(r_len1))));
                            end
                            for (int j = 0; j < 2; j++) begin
                                if (ti == 2'(j + 1)) begin
                                    // tokens hold no space/tab; other ws (VT,FF,CR,LF) skipped
                                    if (r_nph[j] == 2'd0 && c >= 8'd10 && c <= 8'd13) begin
                                    end else if (r_nph[j] == 2'd0 &&
                                                 (c == 8'd43 || c == 8'd45)) begin
                                        r_neg[j] <= c == 8'd45; r_nph[j] <= 2'd1;
                                    end else if (r_nph[j] != 2'd3 &&
                                                 c >= 8'd48 && c <= 8'd57) begin
                                        r_nph[j] <= 2'd2;
                                        r_mag[j] <= (m10[j] > 36'hFFFFFFFF) ?
                                                    33'h100000000 : m10[j][32:0];
                                    end else r_nph[j] <= 2'd3;
                                end
                            end
                        end
                    end
                    if (c == tcld_pkg::CH_NUL || r_idx + 8'd1 >= r_job.len)
                        r_state <= S_DEC;
                    else begin
                        r_idx   <= r_idx + 8'd1;
                        r_state <= S_READ;
                    end
                end
                S_DEC: begin
                    r_res.port <= r_job.port;
                    if (r_job.too_long || !ok) begin
                        r_res.status <= r_job.too_long ? tcld_pkg::ST_TOOLONG
                                                       : tcld_pkg::ST_UNKNOWN;
                        r_res.kind <= '0; r_res.mode <= '0; r_res.v1 <= '0; r_res.v2 <= '0;
                    end else begin
                        r_res.status <= tcld_pkg::ST_OK;
                        r_res.kind <= kind; r_res.mode <= md;
                        r_res.v1 <= v1; r_res.v2 <= v2;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_res_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_read_then_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> r_state == S_SCAN) else $error("read not followed by scan");
    a_scan_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_pend) else $error("scan without read data");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_res_ready |=> r_res_valid && $stable(r_res))
        else $error("result dropped");
`endif

endmodule
